// ===== rtl/mipmap_box_downsample_rgb_defines.svh =====
// ============================================================================
// Assertion macros for the mipmap box downsampler
// Concurrent checks on aclk; empty when SYNTHESIS is defined.
// ============================================================================
`ifndef MIPMAP_BOX_DOWNSAMPLE_RGB_DEFINES_SVH
`define MIPMAP_BOX_DOWNSAMPLE_RGB_DEFINES_SVH

`ifndef SYNTHESIS

// Check that is switched off while reset is asserted.
`define MBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that also runs through reset.
`define MBD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define MBD_ASSERT(label, prop, msg)
`define MBD_ASSERT_RST(label, prop, msg)

`endif

`endif

// ===== rtl/mbd_pkg.sv =====
// ============================================================================
// mbd_pkg
// Shared widths, register indexes and the packed pair-sum type.
// ============================================================================
package mbd_pkg;

    localparam int PIX_W      = 8;     // one color channel
    localparam int SUM_W      = 9;     // sum of two channels
    localparam int PAIR_W     = 3 * SUM_W;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int DIM_OUT_W  = 12;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

    // horizontal pair sums of the three channels
    typedef struct packed {
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } pair_t;

endpackage

// ===== rtl/mbd_line_store.sv =====
// ============================================================================
// mbd_line_store
// Single-port line memory for the pair sums of an even row; registered read.
// ============================================================================
module mbd_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic            aclk,
    input  logic            wr_en,
    input  logic            rd_en,
    input  logic [AW-1:0]   addr,
    input  mbd_pkg::pair_t  wdata,
    output mbd_pkg::pair_t  rd_data
);
    import mbd_pkg::*;

    pair_t mem [DEPTH];
    pair_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mipmap_box_downsample_rgb.sv =====
// ============================================================================
// mipmap_box_downsample_rgb
// 2x2 box filter: RGB888 raster stream in, next mipmap level out.
// ============================================================================
//
//  channel | dir | handshake          | item
//  --------+-----+--------------------+-------------------------------------
//  s_      | in  | s_valid / s_ready  | one source pixel, raster order
//  m_      | out | m_valid / m_ready  | one destination pixel + dims + last
//  cfg_    | in  | cfg_wr_en          | source_width (0), source_height (1)
//
//  Throughput: one item per clock while s_ready is high. m_valid rises once
//  the lower-right pixel of a block has moved from the pipe stage to the
//  output reg (line store read and pipe stage load at the accept edge).
//  Reset: synchronous, active low; counters back to the image origin, sizes 1x1.
//  Stalls: two result registers (pipe stage + output) let the input keep
//  accepting while a result waits; s_ready drops only when both are full
//  and m_ready is low.
//  A config write restarts the image at the origin.
//
module mipmap_box_downsample_rgb #(
    parameter int MAX_WIDTH  = mbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = mbd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic [mbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mbd_pkg::PIX_W-1:0]       s_pixel_red,
    input  logic [mbd_pkg::PIX_W-1:0]       s_pixel_green,
    input  logic [mbd_pkg::PIX_W-1:0]       s_pixel_blue,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mbd_pkg::PIX_W-1:0]       m_out_red,
    output logic [mbd_pkg::PIX_W-1:0]       m_out_green,
    output logic [mbd_pkg::PIX_W-1:0]       m_out_blue,
    output logic [mbd_pkg::DIM_OUT_W-1:0]   m_out_width,
    output logic [mbd_pkg::DIM_OUT_W-1:0]   m_out_height,
    output logic                            m_last_of_image
);
    import mbd_pkg::*;
`include "mipmap_box_downsample_rgb_defines.svh"

    localparam int CW          = $clog2(MAX_WIDTH);        // column counter
    localparam int WW          = $clog2(MAX_WIDTH + 1);    // width value
    localparam int RW          = $clog2(MAX_HEIGHT);       // row counter
    localparam int HW          = $clog2(MAX_HEIGHT + 1);   // height value
    localparam int STORE_DEPTH = MAX_WIDTH / 2;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // ------------------------------------------------------------------
    // Configuration: sizes are clamped to 1..MAX when written, and the
    // destination sizes are derived right away.
    // ------------------------------------------------------------------
    logic [WW-1:0] w_reg, w_next;
    logic [HW-1:0] h_reg, h_next;
    logic [CW-1:0] dw_reg, dw_next;
    logic [RW-1:0] dh_reg, dh_next;

    always_comb begin
        if (cfg_wdata == '0) begin
            w_next = WW'(1);
        end else if (32'(cfg_wdata) > 32'(MAX_WIDTH)) begin
            w_next = WW'(MAX_WIDTH);
        end else begin
            w_next = WW'(cfg_wdata);
        end
        if (cfg_wdata == '0) begin
            h_next = HW'(1);
        end else if (32'(cfg_wdata) > 32'(MAX_HEIGHT)) begin
            h_next = HW'(MAX_HEIGHT);
        end else begin
            h_next = HW'(cfg_wdata);
        end
        dw_next = ((w_next >> 1) == '0) ? CW'(1) : CW'(w_next >> 1);
        dh_next = ((h_next >> 1) == '0) ? RW'(1) : RW'(h_next >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg  <= WW'(1);
            h_reg  <= HW'(1);
            dw_reg <= CW'(1);
            dh_reg <= RW'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SOURCE_WIDTH: begin
                    w_reg  <= w_next;
                    dw_reg <= dw_next;
                end
                REG_SOURCE_HEIGHT: begin
                    h_reg  <= h_next;
                    dh_reg <= dh_next;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front end: position counters, horizontal pairing, line store access
    // ------------------------------------------------------------------
    logic          s_accept;
    logic          p1_advance;
    logic [CW-1:0] x_reg, x_next;
    logic [RW-1:0] y_reg, y_next;

    logic [PIX_W-1:0] first_red_reg, first_green_reg, first_blue_reg;

    logic          w_is_one, h_is_one;
    logic          x_in_pairs, y_in_pairs;
    logic          pair_done;
    logic          first_load;
    pair_t         pair_val;
    logic [AW-1:0] cx;
    logic          st_wr_en, st_rd_en, emit;
    logic          last_col, last_row, last_px;
    pair_t         st_rd_data;

    assign s_accept = s_valid && s_ready;

    assign w_is_one   = (w_reg == WW'(1));
    assign h_is_one   = (h_reg == HW'(1));
    // trailing odd column / row fall outside these
    assign x_in_pairs = {1'b0, x_reg} < {dw_reg, 1'b0};
    assign y_in_pairs = {1'b0, y_reg} < {dh_reg, 1'b0};

    always_comb begin
        pair_done  = 1'b0;
        first_load = 1'b0;
        cx         = '0;
        pair_val.red   = SUM_W'(s_pixel_red)   + SUM_W'(first_red_reg);
        pair_val.green = SUM_W'(s_pixel_green) + SUM_W'(first_green_reg);
        pair_val.blue  = SUM_W'(s_pixel_blue)  + SUM_W'(first_blue_reg);
        if (w_is_one) begin
            // single column: pixel pairs with itself
            pair_val.red   = {s_pixel_red,   1'b0};
            pair_val.green = {s_pixel_green, 1'b0};
            pair_val.blue  = {s_pixel_blue,  1'b0};
            pair_done      = 1'b1;
        end else if (x_in_pairs) begin
            if (!x_reg[0]) begin
                first_load = 1'b1;
            end else begin
                pair_done = 1'b1;
                cx        = AW'(x_reg >> 1);
            end
        end
    end

    assign st_wr_en = s_accept && pair_done && !h_is_one && y_in_pairs && !y_reg[0];
    assign st_rd_en = s_accept && pair_done && !h_is_one && y_in_pairs && y_reg[0];
    assign emit     = s_accept && pair_done && (h_is_one || (y_in_pairs && y_reg[0]));

    assign last_col = (CW'(cx) == (dw_reg - CW'(1)));
    assign last_row = h_is_one || (RW'(y_reg >> 1) == (dh_reg - RW'(1)));
    assign last_px  = last_col && last_row;

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        if (s_accept) begin
            if (x_reg == CW'(w_reg - WW'(1))) begin
                x_next = '0;
                y_next = (y_reg == RW'(h_reg - HW'(1))) ? '0 : y_reg + RW'(1);
            end else begin
                x_next = x_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg <= '0;
            y_reg <= '0;
        end else if (cfg_wr_en) begin
            // new geometry: start over at the origin
            x_reg <= '0;
            y_reg <= '0;
        end else begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    // left pixel of the current horizontal pair
    always_ff @(posedge aclk) begin
        if (s_accept && first_load) begin
            first_red_reg   <= s_pixel_red;
            first_green_reg <= s_pixel_green;
            first_blue_reg  <= s_pixel_blue;
        end
    end

    mbd_line_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .rd_en   (st_rd_en),
        .addr    (cx),
        .wdata   (pair_val),
        .rd_data (st_rd_data)
    );

    // ------------------------------------------------------------------
    // Pipe stage: holds the odd-row pair while the line store read lands.
    // Read data only changes on an accept, which needs this stage to move.
    // ------------------------------------------------------------------
    logic  p1_valid_reg;
    pair_t p1_pair_reg;
    logic  p1_self_reg;
    logic  p1_last_reg;

    assign p1_advance = !m_valid || m_ready;
    assign s_ready    = !p1_valid_reg || p1_advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            p1_valid_reg <= emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            p1_pair_reg <= pair_val;
            p1_self_reg <= h_is_one;   // single row: pair counted twice
            p1_last_reg <= last_px;
        end
    end

    // ------------------------------------------------------------------
    // Vertical sum and divide by four
    // ------------------------------------------------------------------
    pair_t            other;
    logic [SUM_W:0]   sum_red, sum_green, sum_blue;

    assign other     = p1_self_reg ? p1_pair_reg : st_rd_data;
    assign sum_red   = {1'b0, p1_pair_reg.red}   + {1'b0, other.red};
    assign sum_green = {1'b0, p1_pair_reg.green} + {1'b0, other.green};
    assign sum_blue  = {1'b0, p1_pair_reg.blue}  + {1'b0, other.blue};

    logic             m_valid_reg;
    logic [PIX_W-1:0] m_red_reg, m_green_reg, m_blue_reg;
    logic             m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_advance) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_advance && p1_valid_reg) begin
            m_red_reg   <= sum_red[SUM_W:2];
            m_green_reg <= sum_green[SUM_W:2];
            m_blue_reg  <= sum_blue[SUM_W:2];
            m_last_reg  <= p1_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_red       = m_red_reg;
    assign m_out_green     = m_green_reg;
    assign m_out_blue      = m_blue_reg;
    assign m_last_of_image = m_last_reg;
    // the user must change sizes only while idle; the block does not enforce it
    assign m_out_width     = DIM_OUT_W'(dw_reg);
    assign m_out_height    = DIM_OUT_W'(dh_reg);

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `MBD_ASSERT(a_ready_only_when_full,
        !s_ready |-> (p1_valid_reg && m_valid_reg && !m_ready),
        "input stalled with room in the pipe")
    `MBD_ASSERT(a_store_one_port, !(st_wr_en && st_rd_en),
        "line store read and write in one cycle")
    `MBD_ASSERT(a_col_in_range, (WW'(x_reg) < w_reg) && (HW'(y_reg) < h_reg),
        "position counter beyond image size")
    `MBD_ASSERT(a_stage_holds,
        (p1_valid_reg && m_valid_reg && !m_ready) |=>
            (p1_valid_reg && $stable(p1_pair_reg) && $stable(st_rd_data)),
        "pipe stage lost while stalled")
    `MBD_ASSERT_RST(a_reset_empty, !aresetn |=> (!p1_valid_reg && !m_valid_reg),
        "results pending after reset")

endmodule

// ===== verif/mipmap_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// ============================================================================
// mipmap_scoreboard_pkg
// Predicts the 2x2 box downsampler item by item and checks each destination
// pixel against the oldest one predicted.
// ============================================================================
package mipmap_scoreboard_pkg;
    import mbd_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0]     red;
        logic [PIX_W-1:0]     green;
        logic [PIX_W-1:0]     blue;
        logic [DIM_OUT_W-1:0] width;
        logic [DIM_OUT_W-1:0] height;
        logic                 last;
    } dest_pixel_t;

    class downsample_scoreboard;
        logic [CFG_DATA_W-1:0] width_reg;
        logic [CFG_DATA_W-1:0] height_reg;
        int unsigned           column;
        int unsigned           row;
        pair_t                 run_pair;
        pair_t                 row_pairs [DEF_MAX_WIDTH/2];
        dest_pixel_t           dest_due [$];
        int unsigned           mismatches;

        function new();
            width_reg  = CFG_DATA_W'(1);
            height_reg = CFG_DATA_W'(1);
            column     = 0;
            row        = 0;
            run_pair   = '0;
            mismatches = 0;
        endfunction

        // any write restarts the image at the origin
        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] value);
            if (index == REG_SOURCE_WIDTH) begin
                width_reg = value;
            end else begin
                height_reg = value;
            end
            column = 0;
            row    = 0;
        endfunction

        function int unsigned clamp_size(logic [CFG_DATA_W-1:0] size, int unsigned limit);
            if (size == 0) begin
                return 1;
            end
            if (size > limit) begin
                return limit;
            end
            return 32'(size);
        endfunction

        function int unsigned pending();
            return dest_due.size();
        endfunction

        function void note_source_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                        logic [PIX_W-1:0] b);
            int unsigned w, h, dw, dh, cx, dy, sum;
            bit          pair_done, emit;
            pair_t       upper;
            dest_pixel_t px;
            w  = clamp_size(width_reg, DEF_MAX_WIDTH);
            h  = clamp_size(height_reg, DEF_MAX_HEIGHT);
            dw = (w / 2 != 0) ? w / 2 : 1;
            dh = (h / 2 != 0) ? h / 2 : 1;
            pair_done = 1'b0;
            emit      = 1'b0;
            cx        = 0;
            dy        = 0;
            upper     = '0;

            if (w == 1) begin
                // lone column: the pixel pairs with itself
                run_pair.red   = {r, 1'b0};
                run_pair.green = {g, 1'b0};
                run_pair.blue  = {b, 1'b0};
                pair_done      = 1'b1;
            end else if (column < 2 * dw) begin
                if (column % 2 == 0) begin
                    run_pair.red   = {1'b0, r};
                    run_pair.green = {1'b0, g};
                    run_pair.blue  = {1'b0, b};
                end else begin
                    run_pair.red   = run_pair.red + SUM_W'(r);
                    run_pair.green = run_pair.green + SUM_W'(g);
                    run_pair.blue  = run_pair.blue + SUM_W'(b);
                    pair_done      = 1'b1;
                    cx             = column / 2;
                end
            end

            if (pair_done) begin
                if (h == 1) begin
                    upper = run_pair;
                    emit  = 1'b1;
                end else if (row < 2 * dh) begin
                    if (row % 2 == 0) begin
                        row_pairs[cx] = run_pair;
                    end else begin
                        upper = row_pairs[cx];
                        emit  = 1'b1;
                        dy    = row / 2;
                    end
                end
            end

            if (emit) begin
                sum       = 32'(run_pair.red) + 32'(upper.red);
                px.red    = PIX_W'(sum >> 2);
                sum       = 32'(run_pair.green) + 32'(upper.green);
                px.green  = PIX_W'(sum >> 2);
                sum       = 32'(run_pair.blue) + 32'(upper.blue);
                px.blue   = PIX_W'(sum >> 2);
                px.width  = DIM_OUT_W'(dw);
                px.height = DIM_OUT_W'(dh);
                px.last   = (cx == dw - 1) && (dy == dh - 1);
                dest_due.push_back(px);
            end

            column++;
            if (column >= w) begin
                column = 0;
                row++;
                if (row >= h) begin
                    row = 0;
                end
            end
        endfunction

        function string describe(dest_pixel_t px);
            return $sformatf("rgb %0d %0d %0d size %0dx%0d last %0b",
                             px.red, px.green, px.blue, px.width, px.height, px.last);
        endfunction

        function void compare_field(string name, int unsigned due, int unsigned got);
            if (due != got) begin
                mismatches++;
                $display("%0t  %s: expected %0d, actual %0d", $time, name, due, got);
            end
        endfunction

        function void check_dest_pixel(dest_pixel_t got);
            dest_pixel_t due;
            if (dest_due.size() == 0) begin
                mismatches++;
                $display("%0t  pixel: expected none, actual %s", $time, describe(got));
                return;
            end
            due = dest_due.pop_front();
            compare_field("out_red", due.red, got.red);
            compare_field("out_green", due.green, got.green);
            compare_field("out_blue", due.blue, got.blue);
            compare_field("out_width", due.width, got.width);
            compare_field("out_height", due.height, got.height);
            compare_field("last_of_image", due.last, got.last);
        endfunction
    endclass

endpackage

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the mipmap 2x2 box downsampler. A short directed
// pass covers the size corners, then large sizes, some clamped, run on partial
// images, then random small images with random stalls on both sides.
// ============================================================================
module tb_top;
    import mbd_pkg::*;
    import mipmap_scoreboard_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned RANDOM_PIXELS = 700;
    localparam int unsigned BIG_PIXELS    = 200;   // partial image at a large size
    localparam int unsigned IDLE_PCT      = 9;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    logic [PIX_W-1:0]       s_pixel_red   = '0;
    logic [PIX_W-1:0]       s_pixel_green = '0;
    logic [PIX_W-1:0]       s_pixel_blue  = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [PIX_W-1:0]       m_out_red;
    logic [PIX_W-1:0]       m_out_green;
    logic [PIX_W-1:0]       m_out_blue;
    logic [DIM_OUT_W-1:0]   m_out_width;
    logic [DIM_OUT_W-1:0]   m_out_height;
    logic                   m_last_of_image;

    downsample_scoreboard   dest_check;
    int unsigned            pixels_sent = 0;
    int unsigned            cycles      = 0;
    logic                   quiet;

    // one stretch of the run with no idling on either side
    assign quiet = (pixels_sent >= 500) && (pixels_sent < 800);

    mipmap_box_downsample_rgb u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_red     (s_pixel_red),
        .s_pixel_green   (s_pixel_green),
        .s_pixel_blue    (s_pixel_blue),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_red       (m_out_red),
        .m_out_green     (m_out_green),
        .m_out_blue      (m_out_blue),
        .m_out_width     (m_out_width),
        .m_out_height    (m_out_height),
        .m_last_of_image (m_last_of_image)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Monitor: everything that crosses a port at this edge goes to the
    // scoreboard in one place, register writes and source items before
    // results, so the order within the time step never matters.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) begin
                dest_check.write_register(cfg_index, cfg_wdata);
            end
            if (s_valid && s_ready) begin
                dest_check.note_source_pixel(s_pixel_red, s_pixel_green, s_pixel_blue);
                pixels_sent <= pixels_sent + 1;
            end
            if (m_valid && m_ready) begin
                dest_check.check_dest_pixel(dest_pixel_t'{m_out_red, m_out_green,
                    m_out_blue, m_out_width, m_out_height, m_last_of_image});
            end
        end
    end

    // All driver tasks start and end on a falling edge.
    task automatic write_size(input logic [CFG_IDX_W-1:0] index,
                              input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // valid may drop only before the item is presented; once up it holds
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel_red   <= r;
        s_pixel_green <= g;
        s_pixel_blue  <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // channel value with the extremes weighted up
    function automatic logic [PIX_W-1:0] pick_channel();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return PIX_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic send_random_pixel();
        send_pixel(pick_channel(), pick_channel(), pick_channel());
    endtask

    // Idle point for register writes: every predicted pixel has come out,
    // then the bench waits for the two-stage output pipe to settle.
    task automatic drain();
        s_valid <= 1'b0;
        while (dest_check.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    // small sizes, with zero and one turning up often
    function automatic logic [CFG_DATA_W-1:0] pick_size(int unsigned top);
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return CFG_DATA_W'(1);
            end
            default: begin
                return CFG_DATA_W'($urandom_range(2, top));
            end
        endcase
    endfunction

    initial begin : stimulus
        logic [CFG_DATA_W-1:0] w_reg;
        logic [CFG_DATA_W-1:0] h_reg;
        int unsigned           eff_w;
        int unsigned           eff_h;
        int unsigned           images;
        int unsigned           count;
        int unsigned           target;
        int unsigned           phase;
        bit                    keep_height;

        dest_check = new();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed ----
        // reset size is 1x1: every item is a whole image on its own
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd128);
        drain();

        // 3x3: odd trailing column and row are dropped, one pixel out
        write_size(REG_SOURCE_WIDTH, 13'd3);
        write_size(REG_SOURCE_HEIGHT, 13'd3);
        for (int i = 0; i < 9; i++) begin
            send_pixel((i % 2 != 0) ? 8'd255 : 8'd0, 8'd255, PIX_W'(i * 28));
        end
        drain();

        // width of one: the single pixel counts twice
        write_size(REG_SOURCE_WIDTH, 13'd1);
        write_size(REG_SOURCE_HEIGHT, 13'd2);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd253, 8'd1, 8'd0);
        drain();

        // height register zero acts as one: the row pair counts twice
        write_size(REG_SOURCE_WIDTH, 13'd2);
        write_size(REG_SOURCE_HEIGHT, 13'd0);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd254, 8'd3, 8'd1);
        drain();

        // plain 4x2, last flag on the second pixel out
        write_size(REG_SOURCE_WIDTH, 13'd4);
        write_size(REG_SOURCE_HEIGHT, 13'd2);
        repeat (8) send_random_pixel();
        drain();

        // ---- large sizes, partial images only ----
        for (int k = 0; k < 3; k++) begin
            case (k)
                0: begin
                    w_reg = 13'd8191;   // clamps to the widest line
                    h_reg = 13'd0;
                end
                1: begin
                    w_reg = 13'd1;
                    h_reg = 13'd4096;
                end
                default: begin
                    w_reg = 13'd3;
                    h_reg = 13'd4097;   // clamps to the tallest image
                end
            endcase
            write_size(REG_SOURCE_WIDTH, w_reg);
            write_size(REG_SOURCE_HEIGHT, h_reg);
            repeat (BIG_PIXELS) send_random_pixel();
            drain();
        end

        // ---- random small images ----
        // Mostly whole images with random content; some are cut short, so
        // the next one starts mid-image or a write restarts the origin.
        target = pixels_sent + RANDOM_PIXELS;
        phase  = 0;
        h_reg  = 13'd1;
        while (pixels_sent < target) begin
            w_reg       = pick_size(14);
            keep_height = (phase != 0) && ($urandom_range(0, 2) == 0);
            if (keep_height) begin
                write_size(REG_SOURCE_WIDTH, w_reg);
            end else begin
                h_reg = pick_size(10);
                if ($urandom_range(0, 1) == 0) begin
                    write_size(REG_SOURCE_WIDTH, w_reg);
                    write_size(REG_SOURCE_HEIGHT, h_reg);
                end else begin
                    write_size(REG_SOURCE_HEIGHT, h_reg);
                    write_size(REG_SOURCE_WIDTH, w_reg);
                end
            end
            eff_w  = (w_reg == 0) ? 1 : w_reg;
            eff_h  = (h_reg == 0) ? 1 : h_reg;
            images = $urandom_range(1, 3);
            for (int img = 0; img < images; img++) begin
                count = eff_w * eff_h;
                if ($urandom_range(0, 5) == 0) begin
                    count = $urandom_range(1, count);
                end
                repeat (count) send_random_pixel();
            end
            drain();
            phase++;
        end

        // let any stray result show up before the verdict
        repeat (20) @(posedge aclk);
        if (dest_check.mismatches == 0 && dest_check.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mbd_pkg.sv
rtl/mbd_line_store.sv
rtl/mipmap_box_downsample_rgb.sv
verif/mipmap_scoreboard_pkg.sv
verif/tb_top.sv
